// ===== design/hid_kq_pkg.sv =====
// ----------------------------------------------------------------------------
// hid_kq_pkg
// Shared types and constants for the keyboard report event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hid_kq_pkg;

    localparam int QUEUE_DEPTH     = 32;
    localparam int KEYS_PER_REPORT = 6;
    localparam int NUM_SLOTS       = 6;
    localparam int CODE_W          = 8;
    localparam int EVENT_W         = CODE_W + 1;
    localparam int PTR_W           = $clog2(QUEUE_DEPTH);
    localparam int IDX_W           = (KEYS_PER_REPORT > 1) ? $clog2(KEYS_PER_REPORT) : 1;
    localparam int IN_TDATA_W      = NUM_SLOTS * CODE_W;
    localparam int OUT_TDATA_W     = ((EVENT_W + 7) / 8) * 8;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [KEYS_PER_REPORT-1:0][CODE_W-1:0] report_t;

    typedef struct packed {
        logic  pressed;
        code_t code;
    } event_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        event_t wr_event;
    } ring_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESS,
        ST_RELEASE,
        ST_POP,
        ST_POP_DATA
    } state_t;

endpackage

`default_nettype wire

// ===== design/hid_kq_match.sv =====
// ----------------------------------------------------------------------------
// hid_kq_match
// Shared compare unit: does one probe code appear in a report.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_kq_match (
    input  wire hid_kq_pkg::code_t   probe,
    input  wire hid_kq_pkg::report_t keys,
    output logic                     hit
);

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < hid_kq_pkg::KEYS_PER_REPORT; k++)
        begin
            if (keys[k] == probe)
            begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hid_kq_ring.sv =====
// ----------------------------------------------------------------------------
// hid_kq_ring
// Event ring: one-slot-empty circular buffer with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_kq_ring (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire hid_kq_pkg::ring_ctl_t  ctl,
    output hid_kq_pkg::ring_stat_t      stat,
    output hid_kq_pkg::event_t          rd_data
);

    hid_kq_pkg::event_t mem [hid_kq_pkg::QUEUE_DEPTH];

    logic [hid_kq_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hid_kq_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    hid_kq_pkg::event_t           rd_data_reg;

    function automatic logic [hid_kq_pkg::PTR_W-1:0] ptr_inc(
        input logic [hid_kq_pkg::PTR_W-1:0] p
    );
        if (p == hid_kq_pkg::PTR_W'(hid_kq_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = ctl.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = ctl.pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        stat.empty  = (wr_ptr_reg == rd_ptr_reg);
        stat.full   = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // storage: no reset, only written entries are ever read
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= ctl.wr_event;
        end
        if (ctl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/hid_report_key_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// hid_report_key_event_queue_core
// Keyboard report differencer feeding a press/release event ring.
// ----------------------------------------------------------------------------
// An input item is either a six-slot keyboard report (tuser = 0) or a pop
// request (tuser = 1). A report produces no output item; it queues a press
// event for each nonzero new code missing from the stored report, in slot
// order, then a release event for each nonzero stored code missing from the
// new report, and replaces the stored report. A pop produces exactly one
// output item: the oldest event, or an all-zero item with tuser = 0 when the
// ring is empty. The ring holds QUEUE_DEPTH-1 = 31 events; pushes into a
// full ring are dropped. A report occupies the block through its accept
// step and then one probe code per cycle through the single six-way compare
// unit, first the press pass and then the release pass. A pop goes through
// accept, ring read and output load, waiting for the output register to be
// free; on an empty ring it skips the ring read. The block takes one
// item at a time: tready is high only while idle. The output register holds
// a result until taken, so a report can be accepted while a pop result
// still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_key_event_queue_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: key_slot0 [7:0], key_slot1 [15:8], ... key_slot5 [47:40]
    input  wire  [hid_kq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: operation (0 report, 1 pop)
    input  wire                                  s_axis_tuser,
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata: event_pressed [0], event_code [8:1], zero [15:9]
    output logic [hid_kq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: event_valid
    output logic                                 m_axis_tuser
);

    hid_kq_pkg::state_t  state_reg, state_next;
    logic [hid_kq_pkg::IDX_W-1:0] idx_reg, idx_next;
    hid_kq_pkg::report_t cur_reg, cur_next;
    hid_kq_pkg::report_t prev_reg, prev_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_flag_reg, out_flag_next;
    hid_kq_pkg::event_t  out_event_reg, out_event_next;

    // shared compare unit operands
    hid_kq_pkg::code_t   probe;
    hid_kq_pkg::report_t probe_set;
    logic                hit;

    hid_kq_pkg::ring_ctl_t  ring_ctl;
    hid_kq_pkg::ring_stat_t ring_stat;
    hid_kq_pkg::event_t     ring_rd_data;

    logic last_idx;
    logic need_push;
    logic out_free;

    hid_kq_match u_match (
        .probe (probe),
        .keys  (probe_set),
        .hit   (hit)
    );

    hid_kq_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .stat    (ring_stat),
        .rd_data (ring_rd_data)
    );

    // Press pass probes new codes against the stored report, release pass
    // probes stored codes against the new report.
    always_comb
    begin
        if (state_reg == hid_kq_pkg::ST_PRESS)
        begin
            probe     = cur_reg[idx_reg];
            probe_set = prev_reg;
        end
        else
        begin
            probe     = prev_reg[idx_reg];
            probe_set = cur_reg;
        end
    end

    assign last_idx  = (idx_reg == hid_kq_pkg::IDX_W'(hid_kq_pkg::KEYS_PER_REPORT - 1));
    assign need_push = ((state_reg == hid_kq_pkg::ST_PRESS) ||
                        (state_reg == hid_kq_pkg::ST_RELEASE)) &&
                       (probe != '0) && !hit;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_flag_next  = out_flag_reg;
        out_event_next = out_event_reg;
        s_axis_tready  = 1'b0;

        ring_ctl.push             = need_push && !ring_stat.full;
        ring_ctl.pop              = 1'b0;
        ring_ctl.wr_event.pressed = (state_reg == hid_kq_pkg::ST_PRESS);
        ring_ctl.wr_event.code    = probe;

        unique case (state_reg)
            hid_kq_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    for (int k = 0; k < hid_kq_pkg::KEYS_PER_REPORT; k++)
                    begin
                        cur_next[k] = s_axis_tdata[k*hid_kq_pkg::CODE_W +: hid_kq_pkg::CODE_W];
                    end
                    idx_next = '0;
                    if (s_axis_tuser == hid_kq_pkg::OP_POP)
                    begin
                        state_next = hid_kq_pkg::ST_POP;
                    end
                    else
                    begin
                        state_next = hid_kq_pkg::ST_PRESS;
                    end
                end
            end
            hid_kq_pkg::ST_PRESS:
            begin
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = hid_kq_pkg::ST_RELEASE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hid_kq_pkg::ST_RELEASE:
            begin
                if (last_idx)
                begin
                    prev_next  = cur_reg;
                    state_next = hid_kq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hid_kq_pkg::ST_POP:
            begin
                // wait for the output register, then read or answer empty
                if (out_free)
                begin
                    if (ring_stat.empty)
                    begin
                        out_valid_next = 1'b1;
                        out_flag_next  = 1'b0;
                        out_event_next = '0;
                        state_next     = hid_kq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ring_ctl.pop = 1'b1;
                        state_next   = hid_kq_pkg::ST_POP_DATA;
                    end
                end
            end
            hid_kq_pkg::ST_POP_DATA:
            begin
                // output register was freed in the previous cycle
                out_valid_next = 1'b1;
                out_flag_next  = 1'b1;
                out_event_next = ring_rd_data;
                state_next     = hid_kq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hid_kq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hid_kq_pkg::ST_IDLE;
            idx_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_flag_reg  <= out_flag_next;
        out_event_reg <= out_event_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tdata  = {{(hid_kq_pkg::OUT_TDATA_W - hid_kq_pkg::EVENT_W){1'b0}},
                            out_event_reg.code, out_event_reg.pressed};

endmodule

`default_nettype wire

// ===== design/hid_kq_checker.sv =====
// ----------------------------------------------------------------------------
// hid_kq_checker
// Port-level checks for the keyboard report event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_kq_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire [hid_kq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input wire                                s_axis_tuser,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [hid_kq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire                                m_axis_tuser
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // empty-ring answer carries no event
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("empty pop result has nonzero data");

    // a report keeps ready low at the start of its compare passes
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == hid_kq_pkg::OP_REPORT) |=>
            !s_axis_tready ##1 !s_axis_tready)
        else $error("ready returned too early after a report");

    // a report never produces an output item by itself
    a_report_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == hid_kq_pkg::OP_REPORT) &&
            !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("output item appeared after a report");

    logic unused_ok;
    assign unused_ok = ^s_axis_tdata;

endmodule

bind hid_report_key_event_queue_core hid_kq_checker u_hid_kq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/hid_report_key_event_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// hid_report_key_event_queue_core_tb
// Self-checking bench for the keyboard report differencer and its event ring.
// ----------------------------------------------------------------------------
// Reports and pop requests go in on the input stream, and pop results are
// checked against a predictor that keeps its own held-key report and event
// ring. The bench starts with a short directed list: an empty pop, extreme
// codes, a repeated new code, a release of all keys and a ring overflow.
// After that come random runs: typing sequences, bursts that can overflow the ring
// and then drain it, random noise, long output stalls and sender pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_key_event_queue_core_tb;

    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_STALL   = 300;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic              valid;
        logic              pressed;
        hid_kq_pkg::code_t code;
    } key_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the event ring and checks pop results in order
    // ------------------------------------------------------------------------
    class key_event_scoreboard;
        hid_kq_pkg::report_t held_keys;
        hid_kq_pkg::event_t  event_ring [hid_kq_pkg::QUEUE_DEPTH];
        int unsigned         wr_ptr;
        int unsigned         rd_ptr;
        key_result_t         pending_results [$];
        int                  failures;

        function new();
            held_keys = '0;
            wr_ptr    = 0;
            rd_ptr    = 0;
            failures  = 0;
        endfunction

        function int unsigned advance_ptr(int unsigned p);
            return (p + 1 >= hid_kq_pkg::QUEUE_DEPTH) ? 0 : p + 1;
        endfunction

        function int unsigned queued_events();
            return (wr_ptr + hid_kq_pkg::QUEUE_DEPTH - rd_ptr) % hid_kq_pkg::QUEUE_DEPTH;
        endfunction

        // full ring drops the push, pointers stay put
        function void queue_key(logic pressed, hid_kq_pkg::code_t code);
            int unsigned nxt;
            nxt = advance_ptr(wr_ptr);
            if (nxt == rd_ptr)
                return;
            event_ring[wr_ptr].pressed = pressed;
            event_ring[wr_ptr].code    = code;
            wr_ptr = nxt;
        endfunction

        function bit report_holds(hid_kq_pkg::report_t r, hid_kq_pkg::code_t c);
            for (int i = 0; i < hid_kq_pkg::KEYS_PER_REPORT; i++)
                if (r[i] == c)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_input(logic op, logic [hid_kq_pkg::IN_TDATA_W-1:0] data);
            hid_kq_pkg::report_t cur;
            key_result_t         res;
            if (op == hid_kq_pkg::OP_REPORT)
            begin
                cur = data[hid_kq_pkg::KEYS_PER_REPORT*hid_kq_pkg::CODE_W-1:0];
                // presses first, then releases, each in slot order
                for (int i = 0; i < hid_kq_pkg::KEYS_PER_REPORT; i++)
                    if (cur[i] != '0 && !report_holds(held_keys, cur[i]))
                        queue_key(1'b1, cur[i]);
                for (int i = 0; i < hid_kq_pkg::KEYS_PER_REPORT; i++)
                    if (held_keys[i] != '0 && !report_holds(cur, held_keys[i]))
                        queue_key(1'b0, held_keys[i]);
                held_keys = cur;
            end
            else
            begin
                if (rd_ptr == wr_ptr)
                begin
                    res = '0;
                end
                else
                begin
                    res.valid   = 1'b1;
                    res.pressed = event_ring[rd_ptr].pressed;
                    res.code    = event_ring[rd_ptr].code;
                    rd_ptr      = advance_ptr(rd_ptr);
                end
                pending_results.push_back(res);
            end
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTED)
                $display("ERROR: %s", msg);
        endfunction

        function void check_result(logic [hid_kq_pkg::OUT_TDATA_W-1:0] data, logic user);
            key_result_t want;
            key_result_t got;
            got.valid   = user;
            got.pressed = data[0];
            got.code    = data[hid_kq_pkg::CODE_W:1];
            if (pending_results.size() == 0)
            begin
                flag($sformatf("unexpected item: valid=%0b pressed=%0b code=%02h",
                               got.valid, got.pressed, got.code));
                return;
            end
            want = pending_results.pop_front();
            if (got.valid !== want.valid || got.pressed !== want.pressed ||
                got.code !== want.code)
                flag($sformatf({"expected valid=%0b pressed=%0b code=%02h, ",
                                "got valid=%0b pressed=%0b code=%02h"},
                               want.valid, want.pressed, want.code,
                               got.valid, got.pressed, got.code));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [hid_kq_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                               s_axis_tuser  = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [hid_kq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                               m_axis_tuser;

    bit                     stall_request = 1'b0;
    int                     items_sent    = 0;
    key_event_scoreboard    sb;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    hid_report_key_event_queue_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [hid_kq_pkg::IN_TDATA_W-1:0] make_report(
        hid_kq_pkg::code_t s0, hid_kq_pkg::code_t s1, hid_kq_pkg::code_t s2,
        hid_kq_pkg::code_t s3, hid_kq_pkg::code_t s4, hid_kq_pkg::code_t s5);
        return {s5, s4, s3, s2, s1, s0};
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at a rising edge. Valid is left
    // high when no gap follows, so back-to-back items never toggle it.
    // Handshake is judged at the falling edge, where tready is settled.
    // ------------------------------------------------------------------------
    task automatic send_item(logic op, logic [hid_kq_pkg::IN_TDATA_W-1:0] data,
                             bit idle_ok);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        sb.note_input(op, data);
        items_sent++;
        gap = idle_ok ? idle_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pop(bit idle_ok);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_item(hid_kq_pkg::OP_POP, junk[hid_kq_pkg::IN_TDATA_W-1:0], idle_ok);
    endtask

    // waits out pending pop results with valid low; else valid is left alone
    task automatic pause_until_drained();
        if (sb.pending_results.size() == 0)
            return;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() > 0)
            @(posedge clk);
    endtask

    // pop until the predicted ring is empty, then hit the empty case too
    task automatic drain_ring();
        while (sb.queued_events() > 0)
            send_pop(1'b1);
        repeat ($urandom_range(1, 2)) send_pop(1'b1);
    endtask

    // held keys change a slot or two at a time, pops sprinkled in
    task automatic typing_run();
        hid_kq_pkg::report_t keys;
        int                  k;
        keys = sb.held_keys;
        repeat ($urandom_range(3, 10))
        begin
            repeat ($urandom_range(1, 2))
            begin
                k = $urandom_range(0, hid_kq_pkg::KEYS_PER_REPORT - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2: keys[k] = '0;
                    9:       keys[k] = keys[$urandom_range(0, hid_kq_pkg::KEYS_PER_REPORT - 1)];
                    default: keys[k] = hid_kq_pkg::code_t'($urandom_range(1, 255));
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                keys = '0;
            send_item(hid_kq_pkg::OP_REPORT, hid_kq_pkg::IN_TDATA_W'(keys), 1'b1);
            repeat ($urandom_range(0, 2)) send_pop(1'b1);
        end
    endtask

    // back-to-back fresh reports can overflow the ring
    task automatic burst_run();
        hid_kq_pkg::report_t keys;
        repeat ($urandom_range(3, 6))
        begin
            for (int i = 0; i < hid_kq_pkg::KEYS_PER_REPORT; i++)
                keys[i] = ($urandom_range(0, 4) == 0) ?
                          hid_kq_pkg::code_t'(0) :
                          hid_kq_pkg::code_t'($urandom_range(1, 255));
            send_item(hid_kq_pkg::OP_REPORT, hid_kq_pkg::IN_TDATA_W'(keys), 1'b0);
        end
        drain_ring();
    endtask

    task automatic noise_run();
        logic [63:0] junk;
        repeat ($urandom_range(4, 8))
        begin
            junk = {$urandom, $urandom};
            send_item(logic'($urandom_range(0, 1)), junk[hid_kq_pkg::IN_TDATA_W-1:0], 1'b1);
        end
    endtask

    // receiver holds off for a long stretch while pops pile up at the input
    task automatic stall_run();
        stall_request = 1'b1;
        repeat (6) send_pop(1'b0);
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        repeat (2) send_pop(1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random tready, with a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Output item seen valid and ready at the falling edge is taken at the
    // next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int kind;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring pop
        send_pop(1'b1);
        // extreme codes, all new
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA), 1'b1);
        // same report again: no change
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA), 1'b1);
        // repeated new code gives two presses; four releases
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'hFF, 8'h01, 8'h33, 8'h33, 8'h00, 8'h00), 1'b1);
        // all keys up, repeated held code released twice
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
        repeat (8) send_pop(1'b1);
        // two disjoint reports alternated overflow the ring
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15), 1'b0);
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25), 1'b0);
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15), 1'b0);
        send_item(hid_kq_pkg::OP_REPORT,
                  make_report(8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25), 1'b0);
        repeat (3) send_pop(1'b1);

        // random part opens with a drain, a long stall and a full pause
        drain_ring();
        stall_run();
        pause_until_drained();
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
                typing_run();
            else if (kind < 65)
                burst_run();
            else if (kind < 80)
                noise_run();
            else if (kind < 85)
                pause_until_drained();
            else if (kind < 88)
                stall_run();
            else
                repeat ($urandom_range(1, 5)) send_pop(1'b1);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
